@@ src/tgdr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgdr_pkg
// Shared types, constants and tables of the tilted gyro dead reckoning block.
// ----------------------------------------------------------------------------
package tgdr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CNT_W            = 5;

    localparam logic [1:0] REG_TILT_COS = 2'd0;
    localparam logic [1:0] REG_TILT_SIN = 2'd1;
    localparam logic [1:0] REG_PERIOD   = 2'd2;

    localparam logic signed [15:0] TILT_COS_RST = 16'sd10531;
    localparam logic signed [15:0] TILT_SIN_RST = 16'sd12551;
    localparam logic        [15:0] PERIOD_RST   = 16'd655;

    localparam logic [32:0]        DEG360_U = 33'd23592960;
    localparam logic [32:0]        RED_BIAS = 33'd3019898880;
    localparam logic signed [26:0] DEG360   = 27'sd23592960;
    localparam logic signed [26:0] DEG180   = 27'sd11796480;
    localparam logic signed [26:0] DEG90    = 27'sd5898240;
    localparam logic signed [49:0] GAIN_Q30 = 50'sd652032874;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RX,
        ST_MUL_RZ,
        ST_MUL_PER,
        ST_HEAD,
        ST_MUL_GAIN,
        ST_REDUCE,
        ST_FOLD,
        ST_ROTATE,
        ST_ROUND,
        ST_DONE
    } state_t;

    function automatic logic signed [25:0] atan_deg(input logic [CNT_W-1:0] i);
        logic signed [25:0] a;
        case (i)
            5'd0:    a = 26'sd2949120;
            5'd1:    a = 26'sd1740967;
            5'd2:    a = 26'sd919879;
            5'd3:    a = 26'sd466945;
            5'd4:    a = 26'sd234379;
            5'd5:    a = 26'sd117304;
            5'd6:    a = 26'sd58666;
            5'd7:    a = 26'sd29335;
            5'd8:    a = 26'sd14668;
            5'd9:    a = 26'sd7334;
            5'd10:   a = 26'sd3667;
            5'd11:   a = 26'sd1833;
            5'd12:   a = 26'sd917;
            5'd13:   a = 26'sd458;
            5'd14:   a = 26'sd229;
            5'd15:   a = 26'sd115;
            5'd16:   a = 26'sd57;
            5'd17:   a = 26'sd29;
            5'd18:   a = 26'sd14;
            5'd19:   a = 26'sd7;
            5'd20:   a = 26'sd4;
            5'd21:   a = 26'sd2;
            5'd22:   a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/tilted_gyro_dead_reckoning.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilted_gyro_dead_reckoning
// Heading and position integration from a tilted gyro and a distance step.
// ----------------------------------------------------------------------------
// One input beat per sample tick carries rate_x, rate_z and step_distance on
// the s_ channel. Each beat yields one result beat on the m_ channel with the
// updated heading and x/y position, all saturating 32-bit values.
// The cfg channel writes tilt cosine (0), tilt sine (1) and sample period (2);
// other indexes are dropped. cfg_ready is always high.
// One tick runs from accept to result through the bit-serial shift-add
// multiplier, one multiplier bit per cycle for each of four products, the
// modulo-360 reduction at one binary digit per cycle and the CORDIC at one
// iteration per cycle. s_ready is high only between ticks.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished tick waits before overwriting it, so no beat is lost.
// Reset clears heading and position to zero and restores the register
// defaults.
// ----------------------------------------------------------------------------
module tilted_gyro_dead_reckoning #(
    parameter int CORDIC_STEPS = tgdr_pkg::CORDIC_STEPS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire signed  [15:0] s_rate_x,
    input  wire signed  [15:0] s_rate_z,
    input  wire signed  [15:0] s_step_distance,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_heading,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire         [1:0]  cfg_index,
    input  wire         [15:0] cfg_data
);

    localparam int CW = tgdr_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);
    localparam logic [CW-1:0] MUL_LAST  = CW'(15);
    localparam logic [CW-1:0] RED_FIRST = CW'(7);

    tgdr_pkg::state_t state_reg, state_next;

    logic signed [15:0] tcos_reg, tsin_reg;
    logic        [15:0] period_reg;

    logic signed [15:0] rz_reg, rz_next;
    logic signed [15:0] dist_reg, dist_next;
    logic signed [49:0] acc_reg, acc_next;
    logic signed [49:0] mcand_reg, mcand_next;
    logic        [15:0] mplier_reg, mplier_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic        [32:0] red_reg, red_next;
    logic signed [35:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic signed [31:0] head_acc_reg, head_acc_next;
    logic signed [31:0] x_acc_reg, x_acc_next;
    logic signed [31:0] y_acc_reg, y_acc_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_heading_reg, m_heading_next;
    logic signed [31:0] m_pos_x_reg, m_pos_x_next;
    logic signed [31:0] m_pos_y_reg, m_pos_y_next;

    logic signed [49:0] mul_sum, mul_acc, head_rnd, gain_rnd;
    logic signed [33:0] head_sum, xa_sum, ya_sum;
    logic signed [35:0] xs, ys, xf, yf, xr, yr;
    logic        [32:0] red_cmp;
    logic signed [26:0] r_w, r_f;
    logic               sub_mode;

    assign s_ready   = (state_reg == tgdr_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_heading = m_heading_reg;
    assign m_pos_x   = m_pos_x_reg;
    assign m_pos_y   = m_pos_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcos_reg   <= tgdr_pkg::TILT_COS_RST;
            tsin_reg   <= tgdr_pkg::TILT_SIN_RST;
            period_reg <= tgdr_pkg::PERIOD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tgdr_pkg::REG_TILT_COS: tcos_reg   <= cfg_data;
                tgdr_pkg::REG_TILT_SIN: tsin_reg   <= cfg_data;
                tgdr_pkg::REG_PERIOD:   period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tgdr_pkg::ST_IDLE;
            cnt_reg      <= '0;
            head_acc_reg <= '0;
            x_acc_reg    <= '0;
            y_acc_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_acc_reg <= head_acc_next;
            x_acc_reg    <= x_acc_next;
            y_acc_reg    <= y_acc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rz_reg        <= rz_next;
        dist_reg      <= dist_next;
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        red_reg       <= red_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        flip_reg      <= flip_next;
        m_heading_reg <= m_heading_next;
        m_pos_x_reg   <= m_pos_x_next;
        m_pos_y_reg   <= m_pos_y_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rz_next        = rz_reg;
        dist_next      = dist_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        red_next       = red_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        flip_next      = flip_reg;
        head_acc_next  = head_acc_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        m_valid_next   = m_valid_reg;
        m_heading_next = m_heading_reg;
        m_pos_x_next   = m_pos_x_reg;
        m_pos_y_next   = m_pos_y_reg;

        sub_mode = (state_reg != tgdr_pkg::ST_MUL_PER) && (cnt_reg == MUL_LAST);
        mul_sum  = sub_mode ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
        mul_acc  = mplier_reg[0] ? mul_sum : acc_reg;
        head_rnd = acc_reg + 50'sd131072;
        head_sum = {{2{head_acc_reg[31]}}, head_acc_reg}
                 + {{2{head_rnd[49]}}, head_rnd[49:18]};
        gain_rnd = mul_acc + 50'sd8192;
        red_cmp  = tgdr_pkg::DEG360_U << cnt_reg[2:0];
        r_w      = $signed({2'b00, red_reg[24:0]});
        r_f      = (r_w >= tgdr_pkg::DEG180) ? (r_w - tgdr_pkg::DEG360) : r_w;
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        xf       = flip_reg ? -x_reg : x_reg;
        yf       = flip_reg ? -y_reg : y_reg;
        xr       = xf + 36'sd32768;
        yr       = yf + 36'sd32768;
        xa_sum   = {{2{x_acc_reg[31]}}, x_acc_reg} - {{14{yr[35]}}, yr[35:16]};
        ya_sum   = {{2{y_acc_reg[31]}}, y_acc_reg} + {{14{xr[35]}}, xr[35:16]};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tgdr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    rz_next     = s_rate_z;
                    dist_next   = s_step_distance;
                    acc_next    = '0;
                    mcand_next  = {{34{s_rate_x[15]}}, s_rate_x};
                    mplier_next = tcos_reg;
                    cnt_next    = '0;
                    state_next  = tgdr_pkg::ST_MUL_RX;
                end
            end
            tgdr_pkg::ST_MUL_RX, tgdr_pkg::ST_MUL_RZ,
            tgdr_pkg::ST_MUL_PER, tgdr_pkg::ST_MUL_GAIN: begin
                acc_next    = mul_acc;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    cnt_next = '0;
                    case (state_reg)
                        tgdr_pkg::ST_MUL_RX: begin
                            mcand_next  = {{34{rz_reg[15]}}, rz_reg};
                            mplier_next = tsin_reg;
                            state_next  = tgdr_pkg::ST_MUL_RZ;
                        end
                        tgdr_pkg::ST_MUL_RZ: begin
                            mcand_next  = mul_acc;
                            acc_next    = '0;
                            mplier_next = period_reg;
                            state_next  = tgdr_pkg::ST_MUL_PER;
                        end
                        tgdr_pkg::ST_MUL_PER: begin
                            state_next = tgdr_pkg::ST_HEAD;
                        end
                        default: begin
                            x_next     = gain_rnd[49:14];
                            y_next     = '0;
                            red_next   = head_acc_reg[31]
                                       ? (33'(head_acc_reg) + tgdr_pkg::RED_BIAS)
                                       : {1'b0, head_acc_reg};
                            cnt_next   = RED_FIRST;
                            state_next = tgdr_pkg::ST_REDUCE;
                        end
                    endcase
                end
            end
            tgdr_pkg::ST_HEAD: begin
                head_acc_next = tgdr_pkg::sat32(head_sum);
                acc_next      = '0;
                mcand_next    = tgdr_pkg::GAIN_Q30;
                mplier_next   = dist_reg;
                cnt_next      = '0;
                state_next    = tgdr_pkg::ST_MUL_GAIN;
            end
            tgdr_pkg::ST_REDUCE: begin
                if (red_reg >= red_cmp) begin
                    red_next = red_reg - red_cmp;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = tgdr_pkg::ST_FOLD;
                end
            end
            tgdr_pkg::ST_FOLD: begin
                flip_next = 1'b0;
                z_next    = r_f[25:0];
                if (r_f > tgdr_pkg::DEG90) begin
                    z_next    = 26'(r_f - tgdr_pkg::DEG180);
                    flip_next = 1'b1;
                end else if (r_f < -tgdr_pkg::DEG90) begin
                    z_next    = 26'(r_f + tgdr_pkg::DEG180);
                    flip_next = 1'b1;
                end
                cnt_next   = '0;
                state_next = tgdr_pkg::ST_ROTATE;
            end
            tgdr_pkg::ST_ROTATE: begin
                if (!z_reg[25]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tgdr_pkg::atan_deg(cnt_reg);
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tgdr_pkg::atan_deg(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = tgdr_pkg::ST_ROUND;
                end
            end
            tgdr_pkg::ST_ROUND: begin
                x_acc_next = tgdr_pkg::sat32(xa_sum);
                y_acc_next = tgdr_pkg::sat32(ya_sum);
                state_next = tgdr_pkg::ST_DONE;
            end
            tgdr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_heading_next = head_acc_reg;
                    m_pos_x_next   = x_acc_reg;
                    m_pos_y_next   = y_acc_reg;
                    m_valid_next   = 1'b1;
                    state_next     = tgdr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tgdr_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == tgdr_pkg::ST_MUL_RX))
        else $error("accepted beat did not start the multiply");
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == tgdr_pkg::ST_DONE))
        else $error("result beat raised outside the final step");
    a_rotate_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tgdr_pkg::ST_ROTATE) |-> (cnt_reg <= LAST_STEP))
        else $error("CORDIC step count overran");
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tgdr_pkg::ST_ROTATE && cnt_reg == '0)
        |-> (z_reg <= 26'sd5898240 && z_reg >= -26'sd5898240))
        else $error("folded angle out of quarter range");
`endif

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tilted_gyro_dead_reckoning. A driver and a monitor
// run as clocked processes with random idle bursts on both sides; a
// bit-accurate heading/position integrator predicts every result beat, which
// is compared field by field. Several tilt and period settings are visited,
// extremes included, each written while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int         LIMIT     = 4000;
    localparam int         STEPS     = tgdr_pkg::CORDIC_STEPS_DEF;
    localparam longint     FULL_TURN = 64'sd23592960;
    localparam longint     HALF_TURN = 64'sd11796480;
    localparam longint     QTR_TURN  = 64'sd5898240;
    localparam longint     GAIN      = 64'sd652032874;

    typedef struct {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_z;
        logic signed [15:0] step_dist;
    } tick_in_t;

    typedef struct {
        logic signed [31:0] heading;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } pose_t;

    typedef struct {
        logic [1:0]  index;
        logic [15:0] data;
    } reg_wr_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic signed [15:0] s_rate_x = '0;
    logic signed [15:0] s_rate_z = '0;
    logic signed [15:0] s_step_distance = '0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire signed  [31:0] m_heading;
    wire signed  [31:0] m_pos_x;
    wire signed  [31:0] m_pos_y;
    logic               cfg_valid = 1'b0;
    wire                cfg_ready;
    logic        [1:0]  cfg_index = '0;
    logic        [15:0] cfg_data = '0;

    tick_in_t tick_q[$];
    pose_t    pose_q[$];
    reg_wr_t  reg_q[$];

    longint   head_acc, pos_x_acc, pos_y_acc;
    longint   tilt_cos, tilt_sin, period;
    longint   arctan[STEPS];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;
    bit       hold_taken = 1'b0;

    tilted_gyro_dead_reckoning dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic pose_t integrate_tick(input tick_in_t t);
        longint mix, delta, ang, cx, cy, z, xs, ys;
        bit     flip;
        pose_t  p;
        mix = longint'(t.rate_x) * tilt_cos + longint'(t.rate_z) * tilt_sin;
        delta = (mix * period + (64'sd1 <<< 17)) >>> 18;
        head_acc = clamp32(head_acc + delta);
        ang = head_acc % FULL_TURN;
        if (ang < 0) ang += FULL_TURN;
        if (ang >= HALF_TURN) ang -= FULL_TURN;
        flip = 1'b0;
        if (ang > QTR_TURN) begin
            ang -= HALF_TURN;
            flip = 1'b1;
        end else if (ang < -QTR_TURN) begin
            ang += HALF_TURN;
            flip = 1'b1;
        end
        cx = (longint'(t.step_dist) * GAIN + (64'sd1 <<< 13)) >>> 14;
        cy = 0;
        z = ang;
        for (int i = 0; i < STEPS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0) begin
                cx -= ys;
                cy += xs;
                z -= arctan[i];
            end else begin
                cx += ys;
                cy -= xs;
                z += arctan[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        cx = (cx + (64'sd1 <<< 15)) >>> 16;
        cy = (cy + (64'sd1 <<< 15)) >>> 16;
        pos_x_acc = clamp32(pos_x_acc - cy);
        pos_y_acc = clamp32(pos_y_acc + cx);
        p.heading = head_acc[31:0];
        p.pos_x = pos_x_acc[31:0];
        p.pos_y = pos_y_acc[31:0];
        return p;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got), $signed(want),
                 $realtime);
    endtask

    // driver: input beats
    int gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                tick_in_t t;
                t.rate_x = s_rate_x;
                t.rate_z = s_rate_z;
                t.step_dist = s_step_distance;
                pose_q.push_back(integrate_tick(t));
            end
            if (gap > 0) begin
                gap--;
                s_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                tick_in_t t;
                t = tick_q.pop_front();
                s_rate_x <= t.rate_x;
                s_rate_z <= t.rate_z;
                s_step_distance <= t.step_dist;
                s_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // register writes
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (!(cfg_valid && !cfg_ready)) begin
            if (cfg_valid) begin
                case (cfg_index)
                    tgdr_pkg::REG_TILT_COS: tilt_cos = longint'($signed(cfg_data));
                    tgdr_pkg::REG_TILT_SIN: tilt_sin = longint'($signed(cfg_data));
                    tgdr_pkg::REG_PERIOD:   period = longint'({48'd0, cfg_data});
                    default: ;
                endcase
            end
            if (reg_q.size() > 0) begin
                reg_wr_t w;
                w = reg_q.pop_front();
                cfg_index <= w.index;
                cfg_data <= w.data;
                cfg_valid <= 1'b1;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // monitor: result beats
    int stall = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    errors++;
                    $display("unexpected result beat at %0t", $realtime);
                end else begin
                    pose_t p;
                    p = pose_q.pop_front();
                    if (m_heading !== p.heading) report("heading", m_heading, p.heading);
                    if (m_pos_x !== p.pos_x) report("pos_x", m_pos_x, p.pos_x);
                    if (m_pos_y !== p.pos_y) report("pos_y", m_pos_y, p.pos_y);
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall = 700;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_tick(input int rx, input int rz, input int d);
        tick_in_t t;
        t.rate_x = rx[15:0];
        t.rate_z = rz[15:0];
        t.step_dist = d[15:0];
        tick_q.push_back(t);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: add_tick($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                            $urandom_range(0, 65535));
                default: add_tick($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
            endcase
        end
    endtask

    task automatic set_regs(input int c, input int s, input int p);
        reg_wr_t w;
        w.index = tgdr_pkg::REG_TILT_COS; w.data = c[15:0]; reg_q.push_back(w);
        w.index = tgdr_pkg::REG_TILT_SIN; w.data = s[15:0]; reg_q.push_back(w);
        w.index = tgdr_pkg::REG_PERIOD;   w.data = p[15:0]; reg_q.push_back(w);
        wait (reg_q.size() == 0);
        @(posedge aclk);
        wait (!cfg_valid);
    endtask

    task automatic drain;
        wait (tick_q.size() == 0 && !s_valid && pose_q.size() == 0);
        repeat (110) @(posedge aclk);
    endtask

    initial begin
        reg_wr_t w;
        arctan = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
        head_acc = 0;
        pos_x_acc = 0;
        pos_y_acc = 0;
        tilt_cos = 10531;
        tilt_sin = 12551;
        period = 655;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: field extremes
        add_tick(0, 0, 0);
        add_tick(32767, 0, 32767);
        add_tick(-32768, 0, -32768);
        add_tick(0, 32767, 32767);
        add_tick(0, -32768, -32768);
        add_tick(32767, 32767, 1);
        add_tick(-32768, -32768, -1);
        add_random(280);
        drain();

        // full-scale rates with maximum period: heading saturates both ways
        w.index = REG_SPARE; w.data = 16'hffff; reg_q.push_back(w);
        set_regs(32767, 32767, 65535);
        for (int i = 0; i < 10; i++) add_tick(32767, 32767, 32767);
        for (int i = 0; i < 20; i++) add_tick(-32768, -32768, -32768);
        drain();

        set_regs(16384, 0, 65535);
        add_random(150);
        hold_req = 1'b1;
        add_random(150);
        drain();

        // zero period: heading holds
        set_regs(-16384, 16384, 0);
        add_tick(32767, -32768, 32767);
        add_random(250);
        drain();

        set_regs(-32768, -32768, 1);
        add_random(250);
        drain();

        set_regs($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
        add_random(150);
        drain();
        calm = 1'b1;
        set_regs(10531, -12551, 655);
        add_random(250);
        drain();

        if (errors == 0 && pose_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
